// File: rtl/ihb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ihb_pkg
// shared types and constants for the heat-bath ising site update block
// ----------------------------------------------------------------------------
package ihb_pkg;

    // operation codes of an input item
    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_READ   = 2'd1;
    localparam logic [1:0] OP_UPDATE = 2'd2;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;
    localparam int THR_W      = 17;
    localparam int N_THR      = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_THR_M4 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THR_M2 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_THR_0  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_THR_P2 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_THR_P4 = 3'd4;

    localparam logic [THR_W-1:0] THR_RST_M4 = 17'd65001;
    localparam logic [THR_W-1:0] THR_RST_M2 = 17'd60086;
    localparam logic [THR_W-1:0] THR_RST_0  = 17'd32768;
    localparam logic [THR_W-1:0] THR_RST_P2 = 17'd5450;
    localparam logic [THR_W-1:0] THR_RST_P4 = 17'd535;

    // one in probability scale
    localparam logic [THR_W-1:0] THR_ONE = 17'd65536;

    // payload widths fixed by the interface
    localparam int POS_W = 7;
    localparam int RND_W = 16;
    localparam int MAG_W = 16;
    localparam int NRG_W = 17;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD_MID,
        ST_RD_DN,
        ST_GATHER,
        ST_DECIDE
    } t_state;

endpackage

// File: rtl/ising_heat_bath_site_update.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ising_heat_bath_site_update
// periodic 2d ising lattice with load, read and heat-bath update of one site
// ----------------------------------------------------------------------------
//  channel   direction  handshake                   payload
//  in        to block   i_in_valid / o_in_stall     i_opcode i_row i_col i_spin_in
//                                                   i_random_value
//  out       from block o_out_valid / i_out_stall   o_spin_out o_flipped
//                                                   o_magnetization o_bond_energy
//  cfg       to block   i_cfg_we                    i_cfg_idx i_cfg_data
//
//  each item takes three row reads (above, own, below), a gather step and a
//  write-back on the single-port memory
//  reset starts a clearing pass over all SIDE rows, one row per cycle, with the
//  input stalled; configuration writes are taken during it
//  one item is in flight at a time; a new item is taken while a result waits
//  a stalled result holds the block in its last step until the result is taken
// ----------------------------------------------------------------------------
module ising_heat_bath_site_update #(
    parameter int SIDE = 128
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // input items
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic [1:0]                            i_opcode,
    input  logic [ihb_pkg::POS_W-1:0]             i_row,
    input  logic [ihb_pkg::POS_W-1:0]             i_col,
    input  logic                                  i_spin_in,
    input  logic [ihb_pkg::RND_W-1:0]             i_random_value,
    // result items
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic                                  o_spin_out,
    output logic                                  o_flipped,
    output logic signed [ihb_pkg::MAG_W-1:0]      o_magnetization,
    output logic signed [ihb_pkg::NRG_W-1:0]      o_bond_energy,
    // configuration writes
    input  logic                                  i_cfg_we,
    input  logic [ihb_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [ihb_pkg::CFG_DATA_W-1:0]        i_cfg_data
);

    localparam int RW     = $clog2(SIDE);
    localparam int SITES  = SIDE * SIDE;
    localparam int MAG_FW = ($clog2(SITES) + 2 > ihb_pkg::MAG_W) ?
                            $clog2(SITES) + 2 : ihb_pkg::MAG_W;
    localparam int NRG_FW = ($clog2(SITES) + 3 > ihb_pkg::NRG_W) ?
                            $clog2(SITES) + 3 : ihb_pkg::NRG_W;
    localparam int N_POS  = 1 << ihb_pkg::POS_W;

    localparam logic [RW-1:0] LAST_POS = RW'(SIDE - 1);
    localparam logic signed [MAG_FW-1:0] MAG_RST = -MAG_FW'(SITES);
    localparam logic signed [NRG_FW-1:0] NRG_RST = -NRG_FW'(2 * SITES);

    // position reduced modulo SIDE, as a constant lookup
    function automatic logic [N_POS*RW-1:0] build_mod_tbl();
        logic [N_POS*RW-1:0] tbl;
        tbl = '0;
        for (int i = 0; i < N_POS; i++) begin
            tbl[i*RW +: RW] = RW'(i % SIDE);
        end
        return tbl;
    endfunction

    localparam logic [N_POS*RW-1:0] MOD_TBL = build_mod_tbl();

    function automatic logic [RW-1:0] wrap_dec(input logic [RW-1:0] p);
        return (p == '0) ? LAST_POS : p - RW'(1);
    endfunction

    function automatic logic [RW-1:0] wrap_inc(input logic [RW-1:0] p);
        return (p == LAST_POS) ? '0 : p + RW'(1);
    endfunction

    // ------------------------------------------------------------------
    // row memory: one row of SIDE spins per entry, single port
    // ------------------------------------------------------------------
    logic [SIDE-1:0] mem [SIDE];
    logic [SIDE-1:0] r_mem_q;
    logic            mem_we;
    logic            mem_re;
    logic [RW-1:0]   mem_addr;
    logic [SIDE-1:0] mem_wdata;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wdata;
        end else if (mem_re) begin
            r_mem_q <= mem[mem_addr];
        end
    end

    // ------------------------------------------------------------------
    // control and item registers
    // ------------------------------------------------------------------
    ihb_pkg::t_state r_state, n_state;

    logic [RW-1:0]               r_clr_cnt;
    logic [1:0]                  r_op;
    logic [RW-1:0]               r_row;
    logic [RW-1:0]               r_col;
    logic                        r_spin_in;
    logic [ihb_pkg::RND_W-1:0]   r_rnd;
    logic                        r_up_bit;   // spin above
    logic [SIDE-1:0]             r_row_mid;  // own row, written back
    logic [3:0]                  r_nb;       // four neighbour spins
    logic                        r_old;      // spin before the item
    logic [ihb_pkg::THR_W-1:0]   r_thr [ihb_pkg::N_THR];
    logic signed [MAG_FW-1:0]    r_mag;
    logic signed [NRG_FW-1:0]    r_nrg;
    logic                        r_out_valid;
    logic                        r_out_spin;
    logic                        r_out_flip;
    logic signed [MAG_FW-1:0]    r_out_mag;
    logic signed [NRG_FW-1:0]    r_out_nrg;

    logic          in_accept;
    logic          out_free;
    logic          retire;
    logic [RW-1:0] in_row;
    logic [RW-1:0] in_col;

    assign in_row    = MOD_TBL[i_row * RW +: RW];
    assign in_col    = MOD_TBL[i_col * RW +: RW];
    assign in_accept = i_in_valid && !o_in_stall;
    assign out_free  = !r_out_valid || !i_out_stall;
    assign retire    = (r_state == ihb_pkg::ST_DECIDE) && out_free;

    // ------------------------------------------------------------------
    // flip decision for load and heat-bath update, from the gathered neighbour spins
    // ------------------------------------------------------------------
    logic [2:0]                n_up;     // neighbours that are up, 0..4
    logic signed [4:0]         nsum;     // neighbour sum -4..4
    logic signed [5:0]         e_step;
    logic [ihb_pkg::THR_W-1:0] thr_sel;
    logic [ihb_pkg::THR_W-1:0] thr_use;
    logic                      do_flip;
    logic                      new_spin;
    logic [SIDE-1:0]           row_wr;
    logic signed [MAG_FW-1:0]  mag_next;
    logic signed [NRG_FW-1:0]  nrg_next;

    always_comb begin
        n_up    = 3'($countones(r_nb));
        nsum    = signed'({1'b0, n_up, 1'b0}) - 5'sd4;
        e_step  = r_old ? signed'({nsum, 1'b0}) : -signed'({nsum, 1'b0});
        thr_sel = r_thr[n_up];
        // a down spin flips with the complement; above one it never flips
        if (r_old) begin
            thr_use = thr_sel;
        end else if (thr_sel[ihb_pkg::THR_W-1]) begin
            thr_use = '0;
        end else begin
            thr_use = ihb_pkg::THR_ONE - thr_sel;
        end
        case (r_op)
            ihb_pkg::OP_LOAD:   do_flip = (r_old != r_spin_in);
            ihb_pkg::OP_UPDATE: do_flip = ({1'b0, r_rnd} < thr_use);
            default:            do_flip = 1'b0;
        endcase
        new_spin        = r_old ^ do_flip;
        row_wr          = r_row_mid;
        row_wr[r_col]   = new_spin;
        mag_next        = r_mag;
        nrg_next        = r_nrg;
        if (do_flip) begin
            mag_next = r_mag + (r_old ? -MAG_FW'(2) : MAG_FW'(2));
            nrg_next = r_nrg + NRG_FW'(e_step);
        end
    end

    // ------------------------------------------------------------------
    // sequencer: next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            ihb_pkg::ST_CLEAR:  if (r_clr_cnt == LAST_POS) n_state = ihb_pkg::ST_IDLE;
            ihb_pkg::ST_IDLE:   if (in_accept) n_state = ihb_pkg::ST_RD_MID;
            ihb_pkg::ST_RD_MID: n_state = ihb_pkg::ST_RD_DN;
            ihb_pkg::ST_RD_DN:  n_state = ihb_pkg::ST_GATHER;
            ihb_pkg::ST_GATHER: n_state = ihb_pkg::ST_DECIDE;
            ihb_pkg::ST_DECIDE: if (out_free) n_state = ihb_pkg::ST_IDLE;
            default:            n_state = ihb_pkg::ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // sequencer: memory port and handshake
    // ------------------------------------------------------------------
    always_comb begin
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        mem_addr   = r_row;
        mem_wdata  = row_wr;
        o_in_stall = 1'b1;
        case (r_state)
            ihb_pkg::ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_addr  = r_clr_cnt;
                mem_wdata = '0;
            end
            ihb_pkg::ST_IDLE: begin
                // row above is fetched straight from the input item
                o_in_stall = 1'b0;
                mem_re     = i_in_valid;
                mem_addr   = wrap_dec(in_row);
            end
            ihb_pkg::ST_RD_MID: begin
                mem_re   = 1'b1;
                mem_addr = r_row;
            end
            ihb_pkg::ST_RD_DN: begin
                mem_re   = 1'b1;
                mem_addr = wrap_inc(r_row);
            end
            ihb_pkg::ST_DECIDE: begin
                mem_we   = out_free;
                mem_addr = r_row;
            end
            default: begin
                mem_re = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ihb_pkg::ST_CLEAR;
            r_clr_cnt <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ihb_pkg::ST_CLEAR) begin
                r_clr_cnt <= r_clr_cnt + RW'(1);
            end
        end
    end

    // item capture and spin gathering
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_op      <= i_opcode;
            r_row     <= in_row;
            r_col     <= in_col;
            r_spin_in <= i_spin_in;
            r_rnd     <= i_random_value;
        end
        if (r_state == ihb_pkg::ST_RD_MID) begin
            r_up_bit <= r_mem_q[r_col];
        end
        if (r_state == ihb_pkg::ST_RD_DN) begin
            r_row_mid <= r_mem_q;
        end
        if (r_state == ihb_pkg::ST_GATHER) begin
            r_nb  <= {r_up_bit, r_mem_q[r_col],
                      r_row_mid[wrap_dec(r_col)], r_row_mid[wrap_inc(r_col)]};
            r_old <= r_row_mid[r_col];
        end
    end

    // thresholds
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr[0] <= ihb_pkg::THR_RST_M4;
            r_thr[1] <= ihb_pkg::THR_RST_M2;
            r_thr[2] <= ihb_pkg::THR_RST_0;
            r_thr[3] <= ihb_pkg::THR_RST_P2;
            r_thr[4] <= ihb_pkg::THR_RST_P4;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                ihb_pkg::CFG_THR_M4: r_thr[0] <= i_cfg_data;
                ihb_pkg::CFG_THR_M2: r_thr[1] <= i_cfg_data;
                ihb_pkg::CFG_THR_0:  r_thr[2] <= i_cfg_data;
                ihb_pkg::CFG_THR_P2: r_thr[3] <= i_cfg_data;
                ihb_pkg::CFG_THR_P4: r_thr[4] <= i_cfg_data;
                default:             r_thr[0] <= r_thr[0];
            endcase
        end
    end

    // running sums, kept at full width
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mag <= MAG_RST;
            r_nrg <= NRG_RST;
        end else if (retire) begin
            r_mag <= mag_next;
            r_nrg <= nrg_next;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (retire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (retire) begin
            r_out_spin <= new_spin;
            r_out_flip <= do_flip;
            r_out_mag  <= mag_next;
            r_out_nrg  <= nrg_next;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_spin_out      = r_out_spin;
    assign o_flipped       = r_out_flip;
    assign o_magnetization = r_out_mag[ihb_pkg::MAG_W-1:0];
    assign o_bond_energy   = r_out_nrg[ihb_pkg::NRG_W-1:0];

endmodule

// File: rtl/ihb_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ihb_checker
// port-level checks for the heat-bath ising site update block
// ----------------------------------------------------------------------------
module ihb_checker #(
    parameter int SIDE = 128
) (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_in_valid,
    input logic                             o_in_stall,
    input logic                             o_out_valid,
    input logic                             i_out_stall,
    input logic                             o_spin_out,
    input logic                             o_flipped,
    input logic signed [ihb_pkg::MAG_W-1:0] o_magnetization,
    input logic signed [ihb_pkg::NRG_W-1:0] o_bond_energy
);

    localparam logic SIDE_ODD = 1'(SIDE % 2);

    // a held result keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_spin_out)
            && $stable(o_flipped) && $stable(o_magnetization)
            && $stable(o_bond_energy))
        else $error("result changed while stalled");

    // one item in flight: the input closes right after an acceptance
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second item taken while one is in flight");

    // a new result only comes from an item that was being worked on
    a_rise_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared without an item in flight");

    // magnetization keeps the parity of the site count
    a_mag_parity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_magnetization[0] == SIDE_ODD)
        else $error("magnetization parity broken");

endmodule

bind ising_heat_bath_site_update ihb_checker #(.SIDE(SIDE)) u_ihb_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_stall      (o_in_stall),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_spin_out      (o_spin_out),
    .o_flipped       (o_flipped),
    .o_magnetization (o_magnetization),
    .o_bond_energy   (o_bond_energy)
);
